[sv/mo_pkg.sv]
`timescale 1ns / 1ps
package mo_pkg;

	localparam int MO_CORDIC_ITER = 16;
	localparam int MO_CORDIC_MAX  = 24;
	localparam int MO_ANGW        = 34;   // CORDIC datapath width
	localparam int MO_NUMW        = 46;   // divider numerator width
	localparam int MO_DENW        = 19;   // divider denominator width
	localparam logic signed [MO_ANGW-1:0] MO_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [20:0] MO_RATE_TO_BAM = 21'sd683565;
	// floor(n / 1000) = (n * MO_MS_RECIP) >> MO_MS_SHIFT, exact for 0 <= n < 2^45
	localparam logic [43:0] MO_MS_RECIP = 44'd9007199254741;
	localparam int          MO_MS_SHIFT = 53;
	localparam logic [9:0]  MO_MS_ROUND = 10'd999;

	localparam logic [1:0] REG_WHEEL_RADIUS  = 2'd0;
	localparam logic [1:0] REG_HALF_LENGTH_X = 2'd1;
	localparam logic [1:0] REG_HALF_WIDTH_Y  = 2'd2;

	// atan(2^-i) as a 32-bit binary angle
	function automatic logic [29:0] atan_f(input logic [4:0] i);
		logic [29:0] a;
		case (i)
			5'd0: a = 30'd536870912;
			5'd1: a = 30'd316933406;
			5'd2: a = 30'd167458907;
			5'd3: a = 30'd85004756;
			5'd4: a = 30'd42667331;
			5'd5: a = 30'd21354465;
			5'd6: a = 30'd10679838;
			5'd7: a = 30'd5340245;
			5'd8: a = 30'd2670163;
			5'd9: a = 30'd1335087;
			5'd10: a = 30'd667544;
			5'd11: a = 30'd333772;
			5'd12: a = 30'd166886;
			5'd13: a = 30'd83443;
			5'd14: a = 30'd41722;
			5'd15: a = 30'd20861;
			5'd16: a = 30'd10430;
			5'd17: a = 30'd5215;
			5'd18: a = 30'd2608;
			5'd19: a = 30'd1304;
			5'd20: a = 30'd652;
			5'd21: a = 30'd326;
			5'd22: a = 30'd163;
			5'd23: a = 30'd81;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		logic signed [23:0] r;
		if (v > 48'sd8388607) r = 24'sd8388607;
		else if (v < -48'sd8388608) r = -24'sd8388608;
		else r = v[23:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sd2147483647) r = 32'sh7fffffff;
		else if (v < -48'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

[sv/mo_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, floor rounding on signed numerator.
module mo_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [mo_pkg::MO_NUMW-1:0] num,
	input  logic [mo_pkg::MO_DENW-1:0]        den,
	output logic                              done,
	output logic signed [mo_pkg::MO_NUMW:0]   quot
);
	import mo_pkg::*;

	localparam int MW = MO_NUMW - 1;
	localparam int CW = $clog2(MW + 1);

	logic          busy_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] mag_q;
	logic [MO_DENW-1:0] rem_q, den_q;
	logic signed [MO_DENW+1:0] trial;
	logic [MO_NUMW-1:0] abs_num;

	assign abs_num = num[MO_NUMW-1] ? MO_NUMW'(-num) : MO_NUMW'(num);
	assign trial = $signed({1'b0, rem_q, mag_q[MW-1]}) - $signed({2'b00, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[MO_NUMW-1];
			mag_q <= abs_num[MW-1:0];
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[MO_DENW+1]) begin
				rem_q <= trial[MO_DENW-1:0];
				mag_q <= {mag_q[MW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[MO_DENW-2:0], mag_q[MW-1]};
				mag_q <= {mag_q[MW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed({2'b00, mag_q} + (MO_NUMW+1)'(rem_q != '0))
	                    : $signed({2'b00, mag_q});
endmodule

[sv/mo_cordic.sv]
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one micro-rotation per cycle.
module mo_cordic #(
	parameter int ITER = mo_pkg::MO_CORDIC_ITER
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [15:0]                       angle,
	output logic                              done,
	output logic signed [mo_pkg::MO_ANGW-1:0] cos_o,
	output logic signed [mo_pkg::MO_ANGW-1:0] sin_o
);
	import mo_pkg::*;

	localparam int NIT = (ITER < MO_CORDIC_MAX) ? ITER : MO_CORDIC_MAX;

	logic busy_q, done_q, flip_q;
	logic [4:0] i_q;
	logic signed [MO_ANGW-1:0] x_q, y_q, z_q, xs, ys, at;
	logic [31:0] z32;

	assign z32 = {angle ^ {(angle[15] ^ angle[14]), 15'd0}, 16'd0};
	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign at  = $signed({4'd0, atan_f(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 5'(NIT - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= angle[15] ^ angle[14];
			x_q    <= MO_GAIN_Q30;
			y_q    <= '0;
			z_q    <= MO_ANGW'($signed(z32));
		end else if (busy_q) begin
			if (!z_q[MO_ANGW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done  = done_q;
	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;
endmodule

[sv/mecanum_odometry.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_stall  four wheel speeds, elapsed_ms
// out       result     out_valid / out_stall vel_x, vel_y, yaw_rate, pos_x, pos_y, heading
// cfg       write      cfg_wr_en            cfg_idx, cfg_wdata
//
// One request runs from acceptance through the 45-step yaw divider and the CORDIC
// loop, then two position updates, each a reciprocal multiply by 1/1000 (load,
// three 15-bit partial products, result). With Lx + Ly zero the divider is skipped.
// in_stall stays high from acceptance until the result is loaded into the
// output register; a waiting result does not block the next request.
// Reset clears pose to zero and loads the default geometry registers.
module mecanum_odometry #(
	parameter int CORDIC_ITERATIONS = mo_pkg::MO_CORDIC_ITER
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] speed_left_front,
	input  logic signed [15:0] speed_left_back,
	input  logic signed [15:0] speed_right_front,
	input  logic signed [15:0] speed_right_back,
	input  logic [15:0]        elapsed_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] vel_x,
	output logic signed [23:0] vel_y,
	output logic signed [23:0] yaw_rate,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [15:0]        heading
);
	import mo_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_MUL  = 12'b000000000010,
		S_VEL  = 12'b000000000100,
		S_WZW  = 12'b000000001000,
		S_DH   = 12'b000000010000,
		S_DH2  = 12'b000000100000,
		S_COR  = 12'b000001000000,
		S_ROT  = 12'b000010000000,
		S_RXY  = 12'b000100000000,
		S_PXW  = 12'b001000000000,
		S_PYW  = 12'b010000000000,
		S_OUT  = 12'b100000000000
	} state_t;

	// position step: load, three 15-bit partial products, then result
	localparam logic [2:0] PSTEP_LOAD = 3'd0;
	localparam logic [2:0] PSTEP_DONE = 3'd4;

	state_t state_q;

	// geometry registers
	logic [15:0] radius_q, lx_q, ly_q;
	// request capture
	logic signed [15:0] lf_q, lb_q, rf_q, rb_q;
	logic [15:0] ms_q;
	// pose
	logic signed [31:0] posx_q, posy_q;
	logic [15:0] head_q;
	// working values
	logic signed [34:0] pa_q, pb_q, pm_q;
	logic signed [23:0] vx_q, vy_q, wz_q;
	logic signed [40:0] t_q;
	logic signed [57:0] p1_q, p2_q, p3_q, p4_q;
	logic signed [27:0] rx_q, ry_q;
	logic signed [MO_ANGW-1:0] cos_q, sin_q;
	// divide by 1000 for the position step
	logic [2:0]  pcnt_q;
	logic [44:0] pmag_q;
	logic        pneg_q;
	logic [88:0] pacc_q;

	logic signed [17:0] sum_s, dif_s, mix_s;
	logic signed [16:0] r_s, ms_s;
	logic [MO_DENW-1:0] den;
	logic signed [61:0] dh_prod;
	logic [15:0] head_nxt;
	logic signed [58:0] dx, dy;
	logic signed [44:0] mx, my;
	logic signed [44:0] pnum;
	logic [44:0] pnum_mag;
	logic [58:0] pprod;
	logic signed [36:0] pquo;

	logic div_start, div_done, cor_start, cor_done;
	logic signed [MO_NUMW-1:0] div_num;
	logic [MO_DENW-1:0] div_den;
	logic signed [MO_NUMW:0] div_q;
	logic signed [MO_ANGW-1:0] cor_c, cor_s;
	logic signed [47:0] pos_sum;

	assign r_s   = $signed({1'b0, radius_q});
	assign ms_s  = $signed({1'b0, ms_q});
	assign sum_s = 18'(lf_q) + 18'(lb_q) + 18'(rf_q) + 18'(rb_q);
	assign dif_s = 18'(lf_q) - 18'(rf_q) - 18'(lb_q) + 18'(rb_q);
	assign mix_s = 18'(rf_q) - 18'(lf_q) - 18'(lb_q) + 18'(rb_q);
	assign den   = {({1'b0, lx_q} + {1'b0, ly_q}), 2'b00};

	// heading increment: bits 47:32 of wz * ms * 2^32/(2000*pi)
	assign dh_prod  = t_q * MO_RATE_TO_BAM;
	assign head_nxt = head_q + dh_prod[47:32];

	assign dx = 59'(p1_q) - 59'(p2_q);
	assign dy = 59'(p3_q) + 59'(p4_q);
	assign mx = rx_q * ms_s;
	assign my = ry_q * ms_s;

	// floor(n/1000): magnitude (plus 999 when negative) times the reciprocal
	assign pnum     = (state_q == S_PXW) ? mx : my;
	assign pnum_mag = pnum[44] ? 45'(-pnum) + 45'(MO_MS_ROUND) : 45'(pnum);
	assign pprod    = pmag_q[44:30] * MO_MS_RECIP;
	assign pquo     = pneg_q ? -$signed({1'b0, pacc_q[88:MO_MS_SHIFT]})
	                         : $signed({1'b0, pacc_q[88:MO_MS_SHIFT]});
	assign pos_sum  = ((state_q == S_PXW) ? 48'(posx_q) : 48'(posy_q)) + 48'(pquo);

	// divider: yaw rate only
	assign div_start = (state_q == S_VEL) && (den != '0);
	assign div_num   = 46'(pm_q) <<< 8;
	assign div_den   = den;

	assign cor_start = (state_q == S_DH2);

	mo_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_q)
	);

	mo_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cor_start),
		.angle (head_nxt),
		.done  (cor_done),
		.cos_o (cor_c),
		.sin_o (cor_s)
	);

	assign in_stall = (state_q != S_IDLE);

	// sequencer and state that reset clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			radius_q  <= 16'd3277;
			lx_q      <= 16'd9830;
			ly_q      <= 16'd9830;
			posx_q    <= '0;
			posy_q    <= '0;
			head_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx)
					REG_WHEEL_RADIUS:  radius_q <= cfg_wdata;
					REG_HALF_LENGTH_X: lx_q     <= cfg_wdata;
					REG_HALF_WIDTH_Y:  ly_q     <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MUL;
				S_MUL:  state_q <= S_VEL;
				S_VEL:  state_q <= (den != '0) ? S_WZW : S_DH;
				S_WZW:  if (div_done) state_q <= S_DH;
				S_DH:   state_q <= S_DH2;
				S_DH2: begin
					head_q  <= head_nxt;
					state_q <= S_COR;
				end
				S_COR:  if (cor_done) state_q <= S_ROT;
				S_ROT:  state_q <= S_RXY;
				S_RXY:  state_q <= S_PXW;
				S_PXW: if (pcnt_q == PSTEP_DONE) begin
					posx_q  <= sat32(pos_sum);
					state_q <= S_PYW;
				end
				S_PYW: if (pcnt_q == PSTEP_DONE) begin
					posy_q  <= sat32(pos_sum);
					state_q <= S_OUT;
				end
				S_OUT: if (!out_valid || !out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_valid) begin
				lf_q <= speed_left_front;
				lb_q <= speed_left_back;
				rf_q <= speed_right_front;
				rb_q <= speed_right_back;
				ms_q <= elapsed_ms;
			end
			S_MUL: begin
				pa_q <= sum_s * r_s;
				pb_q <= dif_s * r_s;
				pm_q <= mix_s * r_s;
			end
			S_VEL: begin
				vy_q <= sat24(48'(pa_q >>> 10));
				vx_q <= sat24(48'(pb_q >>> 10));
				// no track: yaw rate pins to the rail of the sign of mix * radius, or zero if that is zero
				if (den == '0) begin
					if (pm_q > 0) wz_q <= 24'sd8388607;
					else if (pm_q < 0) wz_q <= -24'sd8388608;
					else wz_q <= '0;
				end
			end
			S_WZW: if (div_done) wz_q <= sat24(48'(div_q));
			S_DH:  t_q <= wz_q * ms_s;
			S_COR: if (cor_done) begin
				cos_q <= cor_c;
				sin_q <= cor_s;
			end
			S_ROT: begin
				p1_q <= vx_q * cos_q;
				p2_q <= vy_q * sin_q;
				p3_q <= vx_q * sin_q;
				p4_q <= vy_q * cos_q;
			end
			S_RXY: begin
				rx_q   <= 28'(dx >>> 30);
				ry_q   <= 28'(dy >>> 30);
				pcnt_q <= PSTEP_LOAD;
			end
			S_PXW, S_PYW: begin
				pcnt_q <= (pcnt_q == PSTEP_DONE) ? PSTEP_LOAD : pcnt_q + 3'd1;
				if (pcnt_q == PSTEP_LOAD) begin
					pmag_q <= pnum_mag;
					pneg_q <= pnum[44];
					pacc_q <= '0;
				end else if (pcnt_q != PSTEP_DONE) begin
					// top 15 bits first, accumulate shifted partial products
					pacc_q <= {pacc_q[73:0], 15'd0} + 89'(pprod);
					pmag_q <= {pmag_q[29:0], 15'd0};
				end
			end
			S_OUT: if (!out_valid || !out_stall) begin
				vel_x    <= vx_q;
				vel_y    <= vy_q;
				yaw_rate <= wz_q;
				pos_x    <= posx_q;
				pos_y    <= posy_q;
				heading  <= head_q;
			end
			default: ;
		endcase
	end
endmodule

[sv/mecanum_odometry_checker.sv]
`timescale 1ns / 1ps
module mecanum_odometry_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [31:0] pos_x
);
	// an accepted request keeps the block busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("busy after accept");

	// a new result appears only as a busy period ends
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall)) else $error("result without work");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");

	a_stab: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pos_x)) else $error("result changed");
endmodule

bind mecanum_odometry mecanum_odometry_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.pos_x    (pos_x)
);
